// File: design/mchw_pkg.sv
// Shared types and constants for the multi-channel heartbeat watchdog.
package mchw_pkg;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned TABLE_MAX    = 16;
  localparam int unsigned TABLE_SLOTS  = (NUM_CHANNELS < TABLE_MAX) ? NUM_CHANNELS : TABLE_MAX;
  localparam int unsigned SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W        = $clog2(TABLE_SLOTS + 1);

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OP_W     = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_BEAT     = 2'd1,
    OP_TICK     = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_NOT_REG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_e;

  // write request into the channel table
  typedef struct packed {
    logic              claim;
    logic              beat;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] timeout;
  } tbl_wr_t;

  // registered read data from the channel table
  typedef struct packed {
    logic              used;
    logic [TIME_W-1:0] beat;
    logic [TIME_W-1:0] timeout;
  } tbl_rd_t;

endpackage

// File: design/mchw_tbl.sv
// Channel table: timestamp and timeout memories, in-use flags, free-slot search.
module mchw_tbl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mchw_pkg::tbl_wr_t                  wr_i,
  input  logic                               rd_en_i,
  input  logic [mchw_pkg::SLOT_W-1:0]        rd_addr_i,
  output mchw_pkg::tbl_rd_t                  rd_o,
  output logic [mchw_pkg::TABLE_SLOTS-1:0]   in_use_o,
  output logic                               free_found_o,
  output logic [mchw_pkg::SLOT_W-1:0]        free_idx_o
);

  logic [mchw_pkg::TIME_W-1:0] beat_mem [mchw_pkg::TABLE_SLOTS];
  logic [mchw_pkg::TIME_W-1:0] tmo_mem  [mchw_pkg::TABLE_SLOTS];
  logic [mchw_pkg::TABLE_SLOTS-1:0] in_use_q;
  mchw_pkg::tbl_rd_t rd_q;

  // memories: no reset, entry contents only used once claimed
  always_ff @(posedge clk_i) begin
    if (wr_i.claim || wr_i.beat) begin
      beat_mem[wr_i.idx] <= wr_i.stamp;
    end
    if (wr_i.claim) begin
      tmo_mem[wr_i.idx] <= wr_i.timeout;
    end
    if (rd_en_i) begin
      rd_q.beat    <= beat_mem[rd_addr_i];
      rd_q.timeout <= tmo_mem[rd_addr_i];
      rd_q.used    <= in_use_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (wr_i.claim) begin
      in_use_q[wr_i.idx] <= 1'b1;
    end
  end

  // lowest free slot
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int k = mchw_pkg::TABLE_SLOTS - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_found_o = 1'b1;
        free_idx_o   = mchw_pkg::SLOT_W'(k);
      end
    end
  end

  assign rd_o     = rd_q;
  assign in_use_o = in_use_q;

endmodule

// File: design/multi_channel_heartbeat_watchdog.sv
// Top level of the multi-channel heartbeat watchdog.
// Register, heartbeat, unused opcode and non-check ticks give their result in the cycle
//   after the input transfer; one item per cycle when results are taken at once.
// A check tick reads all 16 table entries through the single read port, one per cycle:
//   the result is loaded from DONE once the output is free; no input is taken until then.
// Reset (rst_ni low, asynchronous): all slots free, time and period count zero,
//   check period 1, no result pending.
module multi_channel_heartbeat_watchdog (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: check period
  input  logic                                cfg_we_i,
  input  logic [mchw_pkg::PERIOD_W-1:0]       cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mchw_pkg::OP_W-1:0]           opcode_i,
  input  logic [mchw_pkg::CHAN_W-1:0]         channel_i,
  input  logic [mchw_pkg::TIME_W-1:0]         timeout_ticks_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mchw_pkg::STAT_W-1:0]         status_o,
  output logic [mchw_pkg::CHAN_W-1:0]         assigned_channel_o,
  output logic [mchw_pkg::MASK_W-1:0]         timed_out_mask_o,
  output logic                                restart_o,
  output logic                                feed_o
);

  mchw_pkg::fsm_e state_q, state_d;

  logic [mchw_pkg::PERIOD_W-1:0]    check_period_q;
  logic [mchw_pkg::TIME_W-1:0]      time_q, time_d;
  logic [mchw_pkg::PERIOD_W-1:0]    period_q, period_d;
  logic [mchw_pkg::CNT_W-1:0]       scan_idx_q, scan_idx_d;
  logic [mchw_pkg::TABLE_SLOTS-1:0] mask_q, mask_d;
  logic                             cmp_vld_q;
  logic [mchw_pkg::SLOT_W-1:0]      cmp_idx_q;

  // result register
  logic                          out_valid_q;
  logic [mchw_pkg::STAT_W-1:0]   status_q, status_d;
  logic [mchw_pkg::CHAN_W-1:0]   assigned_q, assigned_d;
  logic [mchw_pkg::MASK_W-1:0]   res_mask_q, res_mask_d;
  logic                          restart_q, restart_d;
  logic                          feed_q, feed_d;
  logic                          out_load;
  logic                          out_free;

  // table interface
  mchw_pkg::tbl_wr_t                tbl_wr;
  mchw_pkg::tbl_rd_t                tbl_rd;
  logic                             rd_en;
  logic [mchw_pkg::SLOT_W-1:0]      rd_addr;
  logic [mchw_pkg::TABLE_SLOTS-1:0] in_use;
  logic                             free_found;
  logic [mchw_pkg::SLOT_W-1:0]      free_idx;

  logic                             in_xfer;
  logic [mchw_pkg::PERIOD_W:0]      cnt_next;
  logic [mchw_pkg::PERIOD_W:0]      period_eff;
  logic                             chan_ok;
  logic [mchw_pkg::TIME_W-1:0]      elapsed;
  logic                             hit;

  mchw_tbl u_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_o         (tbl_rd),
    .in_use_o     (in_use),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;

  // a zero period behaves as one
  assign cnt_next   = {1'b0, period_q} + (mchw_pkg::PERIOD_W+1)'(1);
  assign period_eff = (check_period_q == '0) ? (mchw_pkg::PERIOD_W+1)'(1)
                                             : {1'b0, check_period_q};

  // heartbeat only to a claimed slot inside the table
  assign chan_ok = ({1'b0, channel_i} < (mchw_pkg::CHAN_W+1)'(mchw_pkg::TABLE_SLOTS))
                   && in_use[channel_i[mchw_pkg::SLOT_W-1:0]];

  // elapsed time wraps modulo 2^32
  assign elapsed = time_q - tbl_rd.beat;
  assign hit     = tbl_rd.used && (elapsed >= tbl_rd.timeout);

  assign rd_addr = scan_idx_q[mchw_pkg::SLOT_W-1:0];

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    tbl_wr     = '0;
    rd_en      = 1'b0;
    scan_idx_d = scan_idx_q;
    mask_d     = mask_q;
    time_d     = time_q;
    period_d   = period_q;
    out_load   = 1'b0;
    status_d   = mchw_pkg::STAT_OK;
    assigned_d = '0;
    res_mask_d = '0;
    restart_d  = 1'b0;
    feed_d     = 1'b0;

    unique case (state_q)
      mchw_pkg::S_IDLE: begin
        in_ready_o = out_free;
        if (in_xfer) begin
          out_load = 1'b1;
          unique case (mchw_pkg::op_e'(opcode_i))
            mchw_pkg::OP_REGISTER: begin
              if (free_found) begin
                tbl_wr.claim   = 1'b1;
                tbl_wr.idx     = free_idx;
                tbl_wr.stamp   = time_q;
                tbl_wr.timeout = timeout_ticks_i;
                assigned_d     = mchw_pkg::CHAN_W'(free_idx);
              end else begin
                status_d = mchw_pkg::STAT_NO_SLOT;
              end
            end
            mchw_pkg::OP_BEAT: begin
              if (chan_ok) begin
                tbl_wr.beat  = 1'b1;
                tbl_wr.idx   = channel_i[mchw_pkg::SLOT_W-1:0];
                tbl_wr.stamp = time_q;
              end else begin
                status_d = mchw_pkg::STAT_NOT_REG;
              end
            end
            mchw_pkg::OP_TICK: begin
              time_d = time_q + mchw_pkg::TIME_W'(1);
              if (cnt_next >= period_eff) begin
                // check due: result comes after the scan
                period_d   = '0;
                out_load   = 1'b0;
                scan_idx_d = '0;
                mask_d     = '0;
                state_d    = mchw_pkg::S_SCAN;
              end else begin
                period_d = cnt_next[mchw_pkg::PERIOD_W-1:0];
              end
            end
            mchw_pkg::OP_RESERVED: begin
            end
            default: begin
            end
          endcase
        end
      end

      mchw_pkg::S_SCAN: begin
        if (scan_idx_q < mchw_pkg::CNT_W'(mchw_pkg::TABLE_SLOTS)) begin
          rd_en      = 1'b1;
          scan_idx_d = scan_idx_q + mchw_pkg::CNT_W'(1);
        end
        if (cmp_vld_q) begin
          if (hit) begin
            mask_d[cmp_idx_q] = 1'b1;
          end
          if (cmp_idx_q == mchw_pkg::LAST_SLOT) begin
            state_d = mchw_pkg::S_DONE;
          end
        end
      end

      mchw_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_mask_d = mchw_pkg::MASK_W'(mask_q);
          restart_d  = |mask_q;
          feed_d     = 1'b1;
          state_d    = mchw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mchw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= mchw_pkg::S_IDLE;
      check_period_q <= mchw_pkg::PERIOD_W'(1);
      time_q         <= '0;
      period_q       <= '0;
      scan_idx_q     <= '0;
      cmp_vld_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      time_q     <= time_d;
      period_q   <= period_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= rd_en;
      if (cfg_we_i) begin
        check_period_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mask_q    <= mask_d;
    cmp_idx_q <= rd_addr;
    if (out_load) begin
      status_q   <= status_d;
      assigned_q <= assigned_d;
      res_mask_q <= res_mask_d;
      restart_q  <= restart_d;
      feed_q     <= feed_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign assigned_channel_o = assigned_q;
  assign timed_out_mask_o   = res_mask_q;
  assign restart_o          = restart_q;
  assign feed_o             = feed_q;

  // no new transfer while a check scan is in progress
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mchw_pkg::S_IDLE) |-> !in_ready_o)
    else $error("input accepted during check scan");

  // restart only ever comes with a feed and a non-empty mask
  a_restart_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restart_o) |-> (feed_o && (timed_out_mask_o != '0)))
    else $error("restart without feed or mask");

  // check results carry no register or heartbeat status
  a_feed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && feed_o) |->
      ((status_o == mchw_pkg::STAT_OK) && (assigned_channel_o == '0)))
    else $error("check result with register status");

  // a scan moves to DONE in the cycle after the last slot's compare
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mchw_pkg::S_SCAN && cmp_vld_q && cmp_idx_q == mchw_pkg::LAST_SLOT)
      |=> (state_q == mchw_pkg::S_DONE))
    else $error("scan did not finish after last slot");

endmodule

// File: sim/multi_channel_heartbeat_watchdog_tb.sv
// Self-checking testbench for the multi-channel heartbeat watchdog.
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_tb;

  // one response transfer, as seen on the output port
  typedef struct packed {
    mchw_pkg::status_e                status;
    logic [mchw_pkg::CHAN_W-1:0]      assigned;
    logic [mchw_pkg::MASK_W-1:0]      mask;
    logic                             restart;
    logic                             feed;
  } wd_response_t;

  // one line of the directed sequence: either a period write or a command,
  // with the response typed in where it is obvious
  typedef struct packed {
    logic                             is_period_wr;
    mchw_pkg::op_e                    op;
    logic [mchw_pkg::CHAN_W-1:0]      chan;
    logic [mchw_pkg::TIME_W-1:0]      arg;
    logic                             typed;
    wd_response_t                     want;
  } directed_row_t;

  localparam wd_response_t NONE = '{mchw_pkg::STAT_OK, 4'd0, 16'd0, 1'b0, 1'b0};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [mchw_pkg::PERIOD_W-1:0]      cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [mchw_pkg::OP_W-1:0]          opcode_i;
  logic [mchw_pkg::CHAN_W-1:0]        channel_i;
  logic [mchw_pkg::TIME_W-1:0]        timeout_ticks_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [mchw_pkg::STAT_W-1:0]        status_o;
  logic [mchw_pkg::CHAN_W-1:0]        assigned_channel_o;
  logic [mchw_pkg::MASK_W-1:0]        timed_out_mask_o;
  logic                               restart_o;
  logic                               feed_o;

  multi_channel_heartbeat_watchdog dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .channel_i          (channel_i),
    .timeout_ticks_i    (timeout_ticks_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .assigned_channel_o (assigned_channel_o),
    .timed_out_mask_o   (timed_out_mask_o),
    .restart_o          (restart_o),
    .feed_o             (feed_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow of the channel table, time base and check period
  // ---------------------------------------------------------------------
  logic                               sh_used  [mchw_pkg::TABLE_SLOTS];
  logic [mchw_pkg::TIME_W-1:0]        sh_stamp [mchw_pkg::TABLE_SLOTS];
  logic [mchw_pkg::TIME_W-1:0]        sh_limit [mchw_pkg::TABLE_SLOTS];
  logic [mchw_pkg::TIME_W-1:0]        sh_now;
  logic [mchw_pkg::PERIOD_W-1:0]      sh_count;
  logic [mchw_pkg::PERIOD_W-1:0]      sh_period;

  wd_response_t awaited_responses [$];
  int unsigned  mismatch_count;

  // sender / receiver idle rates, in percent
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  // long receiver hold-off, picked up by the receiver process
  int unsigned  hold_off_request;

  // Applies one accepted command to the shadow state and returns the
  // response the block must give for it.
  function automatic wd_response_t compute_watchdog_response(
      mchw_pkg::op_e op,
      logic [mchw_pkg::CHAN_W-1:0] chan,
      logic [mchw_pkg::TIME_W-1:0] arg);
    wd_response_t                     r;
    logic [mchw_pkg::PERIOD_W:0]      next_count;
    logic [mchw_pkg::PERIOD_W:0]      eff_period;
    logic [mchw_pkg::TIME_W-1:0]      elapsed;
    logic                             claimed;
    r = NONE;
    claimed = 1'b0;
    case (op)
      mchw_pkg::OP_REGISTER: begin
        r.status = mchw_pkg::STAT_NO_SLOT;
        for (int k = 0; k < mchw_pkg::TABLE_SLOTS; k++) begin
          if (!claimed && !sh_used[k]) begin
            claimed     = 1'b1;
            sh_used[k]  = 1'b1;
            sh_stamp[k] = sh_now;
            sh_limit[k] = arg;
            r.status    = mchw_pkg::STAT_OK;
            r.assigned  = mchw_pkg::CHAN_W'(k);
          end
        end
      end
      mchw_pkg::OP_BEAT: begin
        if (int'(chan) < mchw_pkg::TABLE_SLOTS && sh_used[chan]) sh_stamp[chan] = sh_now;
        else r.status = mchw_pkg::STAT_NOT_REG;
      end
      mchw_pkg::OP_TICK: begin
        // zero period behaves as one
        eff_period = (sh_period == '0) ? (mchw_pkg::PERIOD_W+1)'(1) : {1'b0, sh_period};
        next_count = {1'b0, sh_count} + 1'b1;
        sh_now     = sh_now + 1'b1;
        if (next_count >= eff_period) begin
          sh_count = '0;
          // wrap-safe elapsed time, flag at or past the limit
          for (int k = 0; k < mchw_pkg::TABLE_SLOTS; k++) begin
            if (sh_used[k]) begin
              elapsed = sh_now - sh_stamp[k];
              if (elapsed >= sh_limit[k]) r.mask[k] = 1'b1;
            end
          end
          r.restart = |r.mask;
          r.feed    = 1'b1;
        end else begin
          sh_count = next_count[mchw_pkg::PERIOD_W-1:0];
        end
      end
      default: ;  // unused opcode: no effect
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Response checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    wd_response_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("unexpected response, status", status_o, 0);
      end else begin
        want = awaited_responses.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (assigned_channel_o !== want.assigned)
          report_mismatch("assigned_channel", assigned_channel_o, want.assigned);
        if (timed_out_mask_o !== want.mask)
          report_mismatch("timed_out_mask", timed_out_mask_o, want.mask);
        if (restart_o !== want.restart)
          report_mismatch("restart", restart_o, want.restart);
        if (feed_o !== want.feed)
          report_mismatch("feed", feed_o, want.feed);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, plus an occasional long hold-off
  // counted here so the sender keeps pushing while the block backs up
  // ---------------------------------------------------------------------
  initial begin : rx_side
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offers one command, returns at the edge it is transferred along with
  // the predicted response. Valid stays high into the next command unless
  // the sender decides to idle.
  task automatic send_command(mchw_pkg::op_e op, logic [mchw_pkg::CHAN_W-1:0] chan,
                              logic [mchw_pkg::TIME_W-1:0] arg,
                              output wd_response_t predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    channel_i       <= chan;
    timeout_ticks_i <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = compute_watchdog_response(op, chan, arg);
  endtask

  // stop offering and wait for every outstanding response
  task automatic drain;
    in_valid_i <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
  endtask

  // period write, only with the block idle
  task automatic write_period(logic [mchw_pkg::PERIOD_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_period    = value;
  endtask

  // Random traffic: mostly ticks and heartbeats, a trickle of registrations
  // so the table fills part way through, and the odd unused opcode.
  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct,
                           logic [mchw_pkg::PERIOD_W-1:0] period, int unsigned n_items,
                           int unsigned hold_cycles);
    wd_response_t                     resp;
    mchw_pkg::op_e                    op;
    logic [mchw_pkg::TIME_W-1:0]      arg;
    int unsigned                      pick;
    write_period(period);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    hold_off_request = hold_cycles;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      arg  = $urandom();
      if (pick < 4) begin
        op = mchw_pkg::OP_REGISTER;
        // mostly short limits so flags come and go; now and then a huge one
        case ($urandom_range(9))
          0:       arg = $urandom();
          1:       arg = $urandom_range(2);
          default: arg = $urandom_range(40, 1);
        endcase
      end else if (pick < 44) op = mchw_pkg::OP_BEAT;
      else if (pick < 96)     op = mchw_pkg::OP_TICK;
      else                    op = mchw_pkg::OP_RESERVED;
      send_command(op, mchw_pkg::CHAN_W'($urandom_range(15)), arg, resp);
      awaited_responses.push_back(resp);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    directed_row_t directed_rows [23];
    wd_response_t  resp;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    opcode_i         = mchw_pkg::OP_TICK;
    channel_i        = '0;
    timeout_ticks_i  = '0;
    mismatch_count   = 0;
    hold_off_request = 0;
    tx_idle_pct      = 15;
    rx_idle_pct      = 80;

    for (int k = 0; k < mchw_pkg::TABLE_SLOTS; k++) begin
      sh_used[k]  = 1'b0;
      sh_stamp[k] = '0;
      sh_limit[k] = '0;
    end
    sh_now    = '0;
    sh_count  = '0;
    sh_period = 16'd1;

    directed_rows = '{
      // heartbeat into an empty table
      '{1'b0, mchw_pkg::OP_BEAT,     4'd0,  32'd0,        1'b1,
        '{mchw_pkg::STAT_NOT_REG, 4'd0, 16'd0, 1'b0, 1'b0}},
      // first tick after reset checks an empty table and feeds
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b1,
        '{mchw_pkg::STAT_OK, 4'd0, 16'd0, 1'b0, 1'b1}},
      '{1'b0, mchw_pkg::OP_RESERVED, 4'd15, 32'hFFFFFFFF, 1'b1, NONE},
      '{1'b0, mchw_pkg::OP_REGISTER, 4'd9,  32'd0,        1'b1,
        '{mchw_pkg::STAT_OK, 4'd0, 16'd0, 1'b0, 1'b0}},
      '{1'b0, mchw_pkg::OP_REGISTER, 4'd0,  32'hFFFFFFFF, 1'b1,
        '{mchw_pkg::STAT_OK, 4'd1, 16'd0, 1'b0, 1'b0}},
      '{1'b0, mchw_pkg::OP_REGISTER, 4'd15, 32'd3,        1'b1,
        '{mchw_pkg::STAT_OK, 4'd2, 16'd0, 1'b0, 1'b0}},
      // zero limit flags at once
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_BEAT,     4'd15, 32'd0,        1'b1,
        '{mchw_pkg::STAT_NOT_REG, 4'd0, 16'd0, 1'b0, 1'b0}},
      '{1'b0, mchw_pkg::OP_BEAT,     4'd2,  32'hFFFFFFFF, 1'b0, NONE},
      // zero period acts as one
      '{1'b1, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b1, mchw_pkg::OP_TICK,     4'd0,  32'd65535,    1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      // period dropped below the running count: check on the next tick
      '{1'b1, mchw_pkg::OP_TICK,     4'd0,  32'd2,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_REGISTER, 4'd5,  32'd1,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_BEAT,     4'd3,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE},
      '{1'b0, mchw_pkg::OP_TICK,     4'd0,  32'd0,        1'b0, NONE}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sequence
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_period_wr) begin
        write_period(directed_rows[i].arg[mchw_pkg::PERIOD_W-1:0]);
      end else begin
        send_command(directed_rows[i].op, directed_rows[i].chan, directed_rows[i].arg, resp);
        awaited_responses.push_back(directed_rows[i].typed ? directed_rows[i].want : resp);
      end
    end

    // random phases: fast sender / busy receiver, then the reverse, then
    // full rate with one long hold-off to back the block up
    run_phase(15, 80, 16'd1, 645, 0);
    run_phase(80, 15, mchw_pkg::PERIOD_W'($urandom_range(7, 2)), 645, 0);
    run_phase(0, 0, mchw_pkg::PERIOD_W'($urandom_range(4, 1)), 645, 300);

    drain();
    repeat (mchw_pkg::TABLE_SLOTS + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog on the run itself
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
design/mchw_pkg.sv
design/mchw_tbl.sv
design/multi_channel_heartbeat_watchdog.sv
sim/multi_channel_heartbeat_watchdog_tb.sv
